[rtl/core/hsm_pkg.sv]
// hsm_pkg: shared constants, register codes and the event word type
// for the Horspool substring matcher. No dependencies.

package hsm_pkg;

	// Sizing
	localparam int MAX_PATTERN_BYTES = 16;
	localparam int POSITION_BITS     = 32;

	// Pattern length / shift values run 0..MAX_PATTERN_BYTES
	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	// Index into the latched pattern bytes
	localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	// Check position needs one bit above the position counter
	localparam int CHK_W = POSITION_BITS + 1;

	// Fixed field widths
	localparam int BYTE_W         = 8;
	localparam int MATCH_START_W  = 32;
	localparam int PAT_REG_W      = 64;
	localparam int PAT_LEN_REG_W  = 5;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_INDEX_W    = 2;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN  = 2'd2;

	// Result kinds
	localparam logic RESULT_MATCH   = 1'b0;
	localparam logic RESULT_SUMMARY = 1'b1;

	// Event queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// One classified byte: an optional match and an optional summary
	typedef struct packed {
		logic                     has_match;
		logic [MATCH_START_W-1:0] match_start;
		logic                     has_summary;
		logic                     any_match;
		logic                     position_overflow;
	} entry_t;

endpackage

[rtl/core/hsm_if.sv]
// hsm_if: valid/ready channel interfaces for text words and result words.
// Depends on hsm_pkg.

interface hsm_text_if;
	import hsm_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              last_byte;

	modport source (output valid, output text_byte, output last_byte, input ready);
	modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface hsm_result_if;
	import hsm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     result_kind;
	logic [MATCH_START_W-1:0] match_start;
	logic                     any_match;
	logic                     position_overflow;
	logic                     last_result;

	modport source (output valid, output result_kind, output match_start,
		output any_match, output position_overflow, output last_result, input ready);
	modport sink   (input valid, input result_kind, input match_start,
		input any_match, input position_overflow, input last_result, output ready);
endinterface

[rtl/core/hsm_front.sv]
// hsm_front: config registers, text window, shift lookup and window compare.
// Classifies each text word into an event entry. Depends on hsm_pkg, hsm_if.

module hsm_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [hsm_pkg::CFG_DATA_W-1:0]     cfg_data,
	hsm_text_if.sink                           text,
	input  logic                               fifo_full,
	output logic                               push,
	output hsm_pkg::entry_t                    push_entry
);
	import hsm_pkg::*;

	// config registers
	logic [PAT_REG_W-1:0]     pat_low_q;
	logic [PAT_REG_W-1:0]     pat_high_q;
	logic [PAT_LEN_REG_W-1:0] pat_len_q;

	// per-text state
	logic [BYTE_W-1:0]        lat_pat_q [MAX_PATTERN_BYTES];
	logic [LEN_W-1:0]         lat_len_q;
	logic                     start_q;
	logic [BYTE_W-1:0]        win_q     [MAX_PATTERN_BYTES];
	logic [POSITION_BITS-1:0] pos_q;
	logic [CHK_W-1:0]         next_q;
	logic                     found_q;
	logic                     ovf_q;

	logic [2*PAT_REG_W-1:0]   cfg_all;
	logic [BYTE_W-1:0]        cfg_pat   [MAX_PATTERN_BYTES];
	logic [LEN_W-1:0]         cfg_len;
	logic [BYTE_W-1:0]        eff_pat   [MAX_PATTERN_BYTES];
	logic [LEN_W-1:0]         eff_len;
	logic [BYTE_W-1:0]        win_nxt   [MAX_PATTERN_BYTES];
	logic [IDX_W-1:0]         lane_idx  [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] lane_ok;
	logic [LEN_W-1:0]         shift;
	logic [CHK_W-1:0]         chk_pos;
	logic                     do_check;
	logic                     hit;
	logic                     pos_max;
	logic [POSITION_BITS-1:0] start_pos;
	logic                     accept;

	assign text.ready = !fifo_full;
	assign accept     = text.valid && text.ready;

	// config image and clamped length
	always_comb begin
		cfg_all = {pat_high_q, pat_low_q};
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			cfg_pat[i] = cfg_all[BYTE_W*i +: BYTE_W];
		end
		if (pat_len_q > PAT_LEN_REG_W'(MAX_PATTERN_BYTES)) begin
			cfg_len = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			cfg_len = LEN_W'(pat_len_q);
		end
	end

	// first word of a text uses the live registers, later words the latched copy
	always_comb begin
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			eff_pat[i] = start_q ? cfg_pat[i] : lat_pat_q[i];
		end
		eff_len = start_q ? cfg_len : lat_len_q;
	end

	// window after this word
	always_comb begin
		win_nxt[0] = text.text_byte;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			win_nxt[k] = win_q[k-1];
		end
	end

	// window lane k holds text byte at pattern index len-1-k
	always_comb begin
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			lane_idx[k] = IDX_W'(eff_len - LEN_W'(1) - LEN_W'(k));
			lane_ok[k]  = (LEN_W'(k) >= eff_len) || (win_nxt[k] == eff_pat[lane_idx[k]]);
		end
	end

	// bad-character shift: rightmost occurrence among the first len-1 bytes wins
	always_comb begin
		shift = eff_len;
		for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
			if ((LEN_W'(i + 1) < eff_len) && (eff_pat[i] == text.text_byte)) begin
				shift = eff_len - LEN_W'(i + 1);
			end
		end
	end

	always_comb begin
		if (start_q) begin
			chk_pos = (eff_len != '0) ? CHK_W'(eff_len - LEN_W'(1)) : '0;
		end else begin
			chk_pos = next_q;
		end
		do_check  = !ovf_q && (eff_len != '0) && ({1'b0, pos_q} == chk_pos);
		hit       = do_check && (&lane_ok);
		pos_max   = (pos_q == {POSITION_BITS{1'b1}});
		start_pos = pos_q - POSITION_BITS'(eff_len - LEN_W'(1));
	end

	assign push = accept && (hit || text.last_byte);

	always_comb begin
		push_entry.has_match         = hit;
		push_entry.match_start       = MATCH_START_W'(start_pos);
		push_entry.has_summary       = text.last_byte;
		push_entry.any_match         = found_q || hit || (eff_len == '0);
		push_entry.position_overflow = ovf_q || pos_max;
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  pat_low_q  <= cfg_data[PAT_REG_W-1:0];
				REG_PATTERN_HIGH: pat_high_q <= cfg_data[PAT_REG_W-1:0];
				REG_PATTERN_LEN:  pat_len_q  <= cfg_data[PAT_LEN_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// per-text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= 1'b1;
			pos_q     <= '0;
			next_q    <= '0;
			found_q   <= 1'b0;
			ovf_q     <= 1'b0;
			lat_len_q <= '0;
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
				win_q[k]     <= '0;
				lat_pat_q[k] <= '0;
			end
		end else if (accept) begin
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
				lat_pat_q[k] <= eff_pat[k];
			end
			lat_len_q <= eff_len;
			if (text.last_byte) begin
				start_q <= 1'b1;
				pos_q   <= '0;
				next_q  <= '0;
				found_q <= 1'b0;
				ovf_q   <= 1'b0;
				for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
					win_q[k] <= '0;
				end
			end else begin
				start_q <= 1'b0;
				for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
					win_q[k] <= win_nxt[k];
				end
				next_q  <= do_check ? (chk_pos + CHK_W'(shift)) : chk_pos;
				found_q <= found_q || hit;
				if (!ovf_q) begin
					if (pos_max) begin
						ovf_q <= 1'b1;
					end else begin
						pos_q <= pos_q + POSITION_BITS'(1);
					end
				end
			end
		end
	end

endmodule

[rtl/core/hsm_fifo.sv]
// hsm_fifo: short event queue between the front and back parts.
// Depends on hsm_pkg.

module hsm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hsm_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output hsm_pkg::entry_t head
);
	import hsm_pkg::*;

	entry_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/core/hsm_back.sv]
// hsm_back: expands queued events into result words behind an output register.
// Depends on hsm_pkg, hsm_if.

module hsm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  hsm_pkg::entry_t head,
	output logic            pop,
	hsm_result_if.source    result
);
	import hsm_pkg::*;

	logic                     valid_q;
	logic                     kind_q;
	logic [MATCH_START_W-1:0] start_q;
	logic                     any_q;
	logic                     ovf_q;
	logic                     last_q;
	logic                     phase_q;   // match of the head entry already sent
	logic                     load;
	logic                     emit_match;

	assign load       = !valid_q || result.ready;
	assign emit_match = head.has_match && !phase_q;
	assign pop        = load && !empty && (!emit_match || !head.has_summary);

	assign result.valid             = valid_q;
	assign result.result_kind       = kind_q;
	assign result.match_start       = start_q;
	assign result.any_match         = any_q;
	assign result.position_overflow = ovf_q;
	assign result.last_result       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				phase_q <= emit_match && head.has_summary;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			if (emit_match) begin
				kind_q  <= RESULT_MATCH;
				start_q <= head.match_start;
				any_q   <= 1'b0;
				ovf_q   <= 1'b0;
				last_q  <= 1'b0;
			end else begin
				kind_q  <= RESULT_SUMMARY;
				start_q <= '0;
				any_q   <= head.any_match;
				ovf_q   <= head.position_overflow;
				last_q  <= 1'b1;
			end
		end
	end

endmodule

[rtl/core/horspool_substring_matcher_unit.sv]
// horspool_substring_matcher_unit: top level of the Horspool substring matcher.
// Depends on hsm_pkg, hsm_if, hsm_front, hsm_fifo, hsm_back.
//
//  channel   dir  handshake      word contents
//  --------  ---  -------------  ------------------------------------------------
//  text      in   valid/ready    text_byte[7:0], last_byte
//  result    out  valid/ready    result_kind, match_start[31:0], any_match,
//                                position_overflow, last_result
//  cfg       in   cfg_we         cfg_index[1:0], cfg_data[63:0] (write only)
//
// One text word per cycle while the event queue is not full: the front does the window compare, shift lookup and
// check-position update in the cycle the word is taken.
// A word with both a match and the end-of-text summary yields two result words;
// the 4-entry event queue absorbs that and short result-side stalls.
// text.ready drops only when the event queue is full.
// A result word passes through the queue write and then the output register
// before it is presented on the result channel.
// Reset (arst_n low) clears the config registers to zero and empties the queue.

module horspool_substring_matcher_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hsm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hsm_pkg::CFG_DATA_W-1:0]  cfg_data,
	hsm_text_if.sink                        text,
	hsm_result_if.source                    result
);
	import hsm_pkg::*;

	// front -> queue
	logic   push;
	entry_t push_entry;
	logic   full;

	// queue -> back
	logic   empty;
	logic   pop;
	entry_t head;

	// Front: holds pattern registers, latches them on the first word of a text,
	// keeps the text window, position and next check point, and turns each
	// word into an event (match start and/or summary) when there is one.
	hsm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.text       (text),
		.fifo_full  (full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Event queue: decouples classification from result delivery.
	hsm_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	// Back: from each event, sends the match word (if any) first, then the summary word (if any).
	hsm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

[rtl/core/hsm_checker.sv]
// hsm_checker: port-level assertions for the matcher, bound to the top level.
// Depends on hsm_pkg, horspool_substring_matcher_unit.

module hsm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic                              res_kind,
	input logic [hsm_pkg::MATCH_START_W-1:0] res_start,
	input logic                              res_any,
	input logic                              res_ovf,
	input logic                              res_last
);
	import hsm_pkg::*;

	// stalled result word holds valid, kind and start
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_start))
		else $error("result word changed while stalled");

	// only the summary closes a text
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_last == (res_kind == RESULT_SUMMARY)))
		else $error("last_result does not track result_kind");

	// match words carry no summary flags
	a_match_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == RESULT_MATCH) |-> !res_any && !res_ovf)
		else $error("summary flags set on a match word");

	// summary words carry no start offset
	a_sum_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_kind == RESULT_SUMMARY) |-> (res_start == '0))
		else $error("match_start set on a summary word");

endmodule

bind horspool_substring_matcher_unit hsm_checker u_hsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_kind  (result.result_kind),
	.res_start (result.match_start),
	.res_any   (result.any_match),
	.res_ovf   (result.position_overflow),
	.res_last  (result.last_result)
);
